FILE: hw/rtl/eis_pkg.sv
// eis_pkg: shared types, register codes and reset values for epipolar inlier scoring
// used by eis_front, eis_back and epipolar_inlier_scoring_top; no dependencies
package eis_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_W = 36;
  localparam int ACC_W = 72;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_LAST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SIGMA = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CHI_THR = 3'd6;

  localparam logic [31:0] COEF_LAST_RST = 32'd16777216;
  localparam logic [23:0] INV_SIGMA_RST = 24'd65536;
  localparam logic [23:0] CHI_THR_RST = 24'd251724;

  typedef struct packed {
    logic [15:0] u_first;
    logic [15:0] v_first;
    logic [15:0] u_second;
    logic [15:0] v_second;
    logic        first_of_set;
  } item_t;

  // f[k*3+j] is row k, column j of the matrix
  typedef struct packed {
    logic [8:0][31:0] f;
    logic [23:0]      inv_sigma_sq;
    logic [23:0]      chi_threshold;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_SCORE,
    ST_DONE
  } state_t;

endpackage

FILE: hw/rtl/eis_front.sv
// eis_front: input side, takes pairs and holds them in a two-entry queue
// depends on eis_pkg
module eis_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  eis_pkg::item_t  in_item,
  input  logic            pop,
  output eis_pkg::item_t  head,
  output eis_pkg::q_stat_t stat
);

  eis_pkg::item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);
  assign in_stall   = stat.full;
  assign push       = in_valid && !in_stall;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: hw/rtl/eis_back.sv
// eis_back: sequencer over one shared multiplier and a restoring divider,
// running totals and the result register; depends on eis_pkg
module eis_back #(
  parameter int COUNT_BITS = eis_pkg::COUNT_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  eis_pkg::cfg_t   cfg,
  input  eis_pkg::q_stat_t q_stat,
  input  eis_pkg::item_t  head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            is_inlier,
  output logic [15:0]     inliers_so_far,
  output logic [31:0]     score_so_far
);

  eis_pkg::state_t state, state_next;
  eis_pkg::item_t  item;

  logic [4:0]  step;
  logic        dir;
  logic        inl;
  logic        dir_ok;
  logic [31:0] score;
  logic [COUNT_BITS-1:0] cnt;

  logic signed [35:0] la, lb, lc, num;
  logic signed [71:0] acc, acc_next, prod;
  logic signed [35:0] opa, opb, fz, lin;
  logic        clr;
  logic [66:0]  den;
  logic [69:0]  sq;
  logic [93:0]  nval;
  logic [117:0] rem;
  logic [90:0]  dsh;
  logic [24:0]  q;
  logic [4:0]   dcnt;
  logic         ge, div_ok, pass, load;
  logic [32:0]  sum;
  logic [15:0]  x1, y1, x2, y2;
  logic [31:0]  cnt_ext;

  function automatic logic signed [35:0] coef(input logic [8:0][31:0] f, input logic d,
                                               input int k, input int j);
    logic [31:0] v;
    v = d ? f[j*3+k] : f[k*3+j];
    return $signed({{4{v[31]}}, v});
  endfunction

  function automatic logic signed [35:0] crd(input logic [15:0] x);
    return $signed({20'd0, x});
  endfunction

  assign x1 = dir ? item.u_second : item.u_first;
  assign y1 = dir ? item.v_second : item.v_first;
  assign x2 = dir ? item.u_first : item.u_second;
  assign y2 = dir ? item.v_first : item.v_second;

  always_comb begin
    opa = '0;
    opb = '0;
    clr = 1'b0;
    fz  = '0;
    unique case (step)
      5'd0: begin opa = coef(cfg.f, dir, 0, 0); opb = crd(x1); clr = 1'b1; end
      5'd1: begin opa = coef(cfg.f, dir, 0, 1); opb = crd(y1); end
      5'd2: begin fz = coef(cfg.f, dir, 0, 2); end
      5'd3: begin opa = coef(cfg.f, dir, 1, 0); opb = crd(x1); clr = 1'b1; end
      5'd4: begin opa = coef(cfg.f, dir, 1, 1); opb = crd(y1); end
      5'd5: begin fz = coef(cfg.f, dir, 1, 2); end
      5'd6: begin opa = coef(cfg.f, dir, 2, 0); opb = crd(x1); clr = 1'b1; end
      5'd7: begin opa = coef(cfg.f, dir, 2, 1); opb = crd(y1); end
      5'd8: begin fz = coef(cfg.f, dir, 2, 2); end
      5'd9: begin opa = la; opb = crd(x2); clr = 1'b1; end
      5'd10: begin opa = lb; opb = crd(y2); end
      5'd11: begin fz = lc; end
      5'd12: begin opa = la; opb = la; clr = 1'b1; end
      5'd13: begin opa = lb; opb = lb; end
      5'd15: begin opa = num; opb = num; clr = 1'b1; end
      5'd17: begin
        opa = $signed({1'b0, sq[34:0]});
        opb = $signed({12'd0, cfg.inv_sigma_sq});
        clr = 1'b1;
      end
      5'd18: begin
        opa = $signed({1'b0, sq[69:35]});
        opb = $signed({12'd0, cfg.inv_sigma_sq});
      end
      default: begin end
    endcase
  end

  assign prod     = opa * opb;
  assign acc_next = (clr ? 72'sd0 : acc) + prod;
  assign lin      = $signed(acc[51:16]) + fz;
  assign div_ok   = (den != 67'd0) && (nval < {26'd0, den, 1'b0});
  assign ge       = rem >= {27'd0, dsh};
  assign pass     = dir_ok && (q <= {1'b0, cfg.chi_threshold});
  assign sum      = {1'b0, score} + {9'd0, cfg.chi_threshold - q[23:0]};
  assign cnt_ext  = 32'(cnt);

  always_comb begin
    state_next = state;
    unique case (state)
      eis_pkg::ST_IDLE:  if (!q_stat.empty) state_next = eis_pkg::ST_CALC;
      eis_pkg::ST_CALC:  if (step == 5'd19) state_next = div_ok ? eis_pkg::ST_DIV
                                                                 : eis_pkg::ST_SCORE;
      eis_pkg::ST_DIV:   if (dcnt == 5'd0) state_next = eis_pkg::ST_SCORE;
      eis_pkg::ST_SCORE: state_next = dir ? eis_pkg::ST_DONE : eis_pkg::ST_CALC;
      eis_pkg::ST_DONE:  if (!out_valid || !out_stall) state_next = eis_pkg::ST_IDLE;
      default:           state_next = eis_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop  = (state == eis_pkg::ST_IDLE) && !q_stat.empty;
    load = (state == eis_pkg::ST_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= eis_pkg::ST_IDLE;
      out_valid <= 1'b0;
      score     <= '0;
      cnt       <= '0;
      step      <= '0;
      dir       <= 1'b0;
      inl       <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        step <= '0;
        dir  <= 1'b0;
        inl  <= 1'b1;
        if (head.first_of_set) begin
          score <= '0;
          cnt   <= '0;
        end
      end
      if (state == eis_pkg::ST_CALC) begin
        step <= step + 5'd1;
      end
      if (state == eis_pkg::ST_SCORE) begin
        step <= '0;
        dir  <= 1'b1;
        inl  <= inl & pass;
        if (pass) begin
          score <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        if (dir && inl && pass && (cnt != {COUNT_BITS{1'b1}})) begin
          cnt <= cnt + COUNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item <= head;
    end
    if (state == eis_pkg::ST_CALC) begin
      acc <= acc_next;
      unique case (step)
        5'd2:  la <= lin;
        5'd5:  lb <= lin;
        5'd8:  lc <= lin;
        5'd11: num <= lin;
        5'd14: den <= acc[66:0];
        5'd16: sq <= acc[69:0];
        5'd18: nval <= {prod[58:0], 35'd0} + {35'd0, acc[58:0]};
        5'd19: begin
          dir_ok <= div_ok;
          rem    <= {nval, 24'd0};
          dsh    <= {den, 24'd0};
          q      <= '0;
          dcnt   <= 5'd24;
        end
        default: begin end
      endcase
    end
    if (state == eis_pkg::ST_DIV) begin
      if (ge) begin
        rem <= rem - {27'd0, dsh};
      end
      q    <= {q[23:0], ge};
      dsh  <= dsh >> 1;
      dcnt <= dcnt - 5'd1;
    end
    if (load) begin
      is_inlier      <= inl;
      inliers_so_far <= cnt_ext[15:0];
      score_so_far   <= score;
    end
  end

endmodule

FILE: hw/rtl/epipolar_inlier_scoring_top.sv
// epipolar_inlier_scoring_top: configuration registers, front queue and back sequencer
// depends on eis_pkg, eis_front, eis_back
//
// usage:
//   input channel (in_valid/in_stall) carries one matched pair per transfer;
//   first_of_set clears the running score and count before that pair counts
//   output channel (out_valid/out_stall) gives is_inlier and the running totals
//   config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
//   write it only while no pair is in flight
// timing:
//   each pair takes 94 cycles in the back end (44 when both directions fail
//   early), set by the 20-step schedule on the one 36x36 multiplier and the
//   25-step restoring divider, run once per direction
//   the two-entry queue takes new pairs while the back end works
// reset:
//   clears queue, totals and output valid; registers return to defaults
// stall:
//   a stalled result holds in the output register; the back end waits after
//   finishing the next pair, and the queue fills and then stalls the input
module epipolar_inlier_scoring_top #(
  parameter int COUNT_BITS = eis_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] u_first,
  input  logic [15:0] v_first,
  input  logic [15:0] u_second,
  input  logic [15:0] v_second,
  input  logic        first_of_set,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_inlier,
  output logic [15:0] inliers_so_far,
  output logic [31:0] score_so_far,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [eis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0] cfg_data
);

  eis_pkg::cfg_t    cfg;
  eis_pkg::item_t   in_item;
  eis_pkg::item_t   head;
  eis_pkg::q_stat_t q_stat;
  logic             pop;
  logic [63:0] coef_a, coef_b, coef_c, coef_d;
  logic [31:0] coef_last;
  logic [23:0] inv_sigma_sq;
  logic [23:0] chi_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a        <= '0;
      coef_b        <= '0;
      coef_c        <= '0;
      coef_d        <= '0;
      coef_last     <= eis_pkg::COEF_LAST_RST;
      inv_sigma_sq  <= eis_pkg::INV_SIGMA_RST;
      chi_threshold <= eis_pkg::CHI_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        eis_pkg::CFG_COEF_A:    coef_a <= cfg_data;
        eis_pkg::CFG_COEF_B:    coef_b <= cfg_data;
        eis_pkg::CFG_COEF_C:    coef_c <= cfg_data;
        eis_pkg::CFG_COEF_D:    coef_d <= cfg_data;
        eis_pkg::CFG_COEF_LAST: coef_last <= cfg_data[31:0];
        eis_pkg::CFG_INV_SIGMA: inv_sigma_sq <= cfg_data[23:0];
        eis_pkg::CFG_CHI_THR:   chi_threshold <= cfg_data[23:0];
        default: begin end
      endcase
    end
  end

  // row-major f11..f33
  assign cfg.f[0] = coef_a[63:32];
  assign cfg.f[1] = coef_a[31:0];
  assign cfg.f[2] = coef_b[63:32];
  assign cfg.f[3] = coef_b[31:0];
  assign cfg.f[4] = coef_c[63:32];
  assign cfg.f[5] = coef_c[31:0];
  assign cfg.f[6] = coef_d[63:32];
  assign cfg.f[7] = coef_d[31:0];
  assign cfg.f[8] = coef_last;
  assign cfg.inv_sigma_sq  = inv_sigma_sq;
  assign cfg.chi_threshold = chi_threshold;

  assign in_item.u_first      = u_first;
  assign in_item.v_first      = v_first;
  assign in_item.u_second     = u_second;
  assign in_item.v_second     = v_second;
  assign in_item.first_of_set = first_of_set;

  eis_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  eis_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_stat         (q_stat),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .is_inlier      (is_inlier),
    .inliers_so_far (inliers_so_far),
    .score_so_far   (score_so_far)
  );

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_stat.empty |-> !pop)
    else $error("pop from empty queue");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_stat.full)
    else $error("input stalled with queue space");

endmodule
